// ===== hdl/vrp_pkg.sv =====
package vrp_pkg;

  localparam int ANGLE_W    = 16;
  localparam int ANGLE_FRAC = 14;
  localparam int DIST_W     = 12;
  localparam int SCREEN_W   = 13;
  localparam int OUT_W      = 16;
  // quotient magnitude bits kept by the divider; anything larger saturates
  localparam int QUOT_BITS  = 17;

  localparam logic signed [OUT_W-1:0] IGNORE_COORD = -16'sd666;
  localparam logic signed [OUT_W-1:0] SAT_MAX      = 16'sd32767;
  localparam logic signed [OUT_W-1:0] SAT_MIN      = -16'sd32768;

  typedef enum logic [2:0] {
    REG_SIN    = 3'd0,
    REG_COS    = 3'd1,
    REG_CAM_X  = 3'd2,
    REG_CAM_Y  = 3'd3,
    REG_CAM_Z  = 3'd4,
    REG_DIST   = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } cfg_reg_t;

  // per-item flags carried alongside the divider data
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } vrp_flags_t;

endpackage

// ===== hdl/vrp_rotate.sv =====
module vrp_rotate #(
  parameter int CB = 24,
  localparam int PW = CB + vrp_pkg::ANGLE_W,
  localparam int XW = CB + vrp_pkg::ANGLE_W + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [CB-1:0]                 x,
  input  logic signed [CB-1:0]                 y,
  input  logic signed [CB-1:0]                 z,
  input  logic                                 hidden,
  input  logic signed [vrp_pkg::ANGLE_W-1:0]   sin_angle,
  input  logic signed [vrp_pkg::ANGLE_W-1:0]   cos_angle,
  input  logic signed [CB-1:0]                 cam_x,
  input  logic signed [CB-1:0]                 cam_y,
  input  logic signed [CB-1:0]                 cam_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [XW-1:0]                 xr,
  output logic signed [XW-1:0]                 yr,
  output logic signed [XW-1:0]                 zr,
  output logic                                 out_hidden
);

  logic                 v1;
  logic signed [PW-1:0] pxc, pzs, pxs, pzc;
  logic signed [CB-1:0] y1;
  logic                 h1;
  logic                 rdy1, rdy2;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      pxc <= PW'(x) * PW'(cos_angle);
      pzs <= PW'(z) * PW'(sin_angle);
      pxs <= PW'(x) * PW'(sin_angle);
      pzc <= PW'(z) * PW'(cos_angle);
      y1  <= y;
      h1  <= hidden;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
    if (rdy2) begin
      xr <= XW'(pxc) - XW'(pzs) + (XW'(cam_x) <<< vrp_pkg::ANGLE_FRAC);
      yr <= (XW'(y1) + XW'(cam_y)) <<< vrp_pkg::ANGLE_FRAC;
      zr <= XW'(pxs) + XW'(pzc) + (XW'(cam_z) <<< vrp_pkg::ANGLE_FRAC);
      out_hidden <= h1;
    end
  end

endmodule

// ===== hdl/vrp_scale.sv =====
module vrp_scale #(
  parameter int XW = 41,
  parameter int FRAC_BITS = 8,
  localparam int NW = XW + vrp_pkg::DIST_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [XW-1:0]             xr,
  input  logic signed [XW-1:0]             yr,
  input  logic signed [XW-1:0]             zr,
  input  logic                             hidden,
  input  logic [vrp_pkg::DIST_W-1:0]       view_distance,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [NW-1:0]                    mag_x,
  output logic [NW-1:0]                    mag_y,
  output logic [XW-2:0]                    den,
  output vrp_pkg::vrp_flags_t              flags
);

  // zr must exceed 2.0 in the rotated scale
  localparam logic signed [XW-1:0] ZLIM = XW'(1) <<< (FRAC_BITS + vrp_pkg::ANGLE_FRAC + 1);

  logic                 va;
  logic signed [NW-1:0] nx, ny;
  logic signed [XW-1:0] za;
  logic                 visa;
  logic                 rdya, rdyb;

  assign rdyb     = !out_valid || out_ready;
  assign rdya     = !va || rdyb;
  assign in_ready = rdya;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdya) begin
      va <= in_valid;
    end
    if (rdya) begin
      nx   <= NW'(signed'({1'b0, view_distance})) * NW'(xr);
      ny   <= NW'(signed'({1'b0, view_distance})) * NW'(yr);
      za   <= zr;
      visa <= !hidden && (zr > ZLIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdyb) begin
      out_valid <= va;
    end
    if (rdyb) begin
      mag_x       <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      mag_y       <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      den         <= za[XW-2:0];
      flags.vis   <= visa;
      flags.neg_x <= nx[NW-1];
      flags.neg_y <= ny[NW-1];
    end
  end

endmodule

// ===== hdl/vrp_div.sv =====
module vrp_div #(
  parameter int NW = 53,
  parameter int DW = 40,
  localparam int QB = vrp_pkg::QUOT_BITS,
  localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NW-1:0]        num_x,
  input  logic [NW-1:0]        num_y,
  input  logic [DW-1:0]        den,
  input  vrp_pkg::vrp_flags_t  in_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [QB-1:0]        quot_x,
  output logic [QB-1:0]        quot_y,
  output logic                 ovf_x,
  output logic                 ovf_y,
  output vrp_pkg::vrp_flags_t  out_flags
);

  // stage 0 checks for quotient overflow, stages 1..QB each retire one bit
  logic                v  [0:QB];
  logic                rdy[0:QB];
  logic [RW-1:0]       rx [0:QB];
  logic [RW-1:0]       ry [0:QB];
  logic [DW-1:0]       d  [0:QB];
  logic [QB-1:0]       qx [0:QB];
  logic [QB-1:0]       qy [0:QB];
  logic                ox [0:QB];
  logic                oy [0:QB];
  vrp_pkg::vrp_flags_t fl [0:QB];

  assign in_ready  = rdy[0];
  assign out_valid = v[QB];
  assign quot_x    = qx[QB];
  assign quot_y    = qy[QB];
  assign ovf_x     = ox[QB];
  assign ovf_y     = oy[QB];
  assign out_flags = fl[QB];

  for (genvar j = 0; j <= QB; j++) begin : g_stage
    if (j == QB) begin : g_last
      assign rdy[j] = !v[j] || out_ready;
    end else begin : g_mid
      assign rdy[j] = !v[j] || rdy[j+1];
    end

    if (j == 0) begin : g_ovf
      logic [RW-1:0] lim;
      assign lim = RW'(den) << QB;
      always_ff @(posedge clk) begin
        if (rst) begin
          v[j] <= 1'b0;
        end else if (rdy[j]) begin
          v[j] <= in_valid;
        end
        if (rdy[j]) begin
          rx[j] <= RW'(num_x);
          ry[j] <= RW'(num_y);
          d[j]  <= den;
          qx[j] <= '0;
          qy[j] <= '0;
          ox[j] <= RW'(num_x) >= lim;
          oy[j] <= RW'(num_y) >= lim;
          fl[j] <= in_flags;
        end
      end
    end else begin : g_bit
      localparam int K = QB - j;
      logic [RW-1:0] t;
      logic          gx, gy;
      assign t  = RW'(d[j-1]) << K;
      assign gx = rx[j-1] >= t;
      assign gy = ry[j-1] >= t;
      always_ff @(posedge clk) begin
        if (rst) begin
          v[j] <= 1'b0;
        end else if (rdy[j]) begin
          v[j] <= v[j-1];
        end
        if (rdy[j]) begin
          rx[j] <= gx ? rx[j-1] - t : rx[j-1];
          ry[j] <= gy ? ry[j-1] - t : ry[j-1];
          qx[j] <= qx[j-1] | (QB'(gx) << K);
          qy[j] <= qy[j-1] | (QB'(gy) << K);
          d[j]  <= d[j-1];
          ox[j] <= ox[j-1];
          oy[j] <= oy[j-1];
          fl[j] <= fl[j-1];
        end
      end
    end
  end

endmodule

// ===== hdl/vertex_rotate_project.sv =====
// Pipeline stages from input item to result item: 2 rotate, 2 scale,
// 18 divider, 1 output stage.
// Throughput: one item per cycle; the divider is fully pipelined, one quotient
// bit per stage for x and y; a stall squeezes out bubbles, then stalls input.
// Reset (rst, synchronous): empties the pipeline and loads the default
// configuration (no rotation, camera z 256.0, distance 256, 640x480 screen).
module vertex_rotate_project #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8,
  localparam int IN_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // in_x, in_y, in_z, zero pad
  input  logic                  s_axis_tuser,   // in_hidden
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // screen_x, screen_y
  output logic                  m_axis_tuser,   // visible
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int XW = CB + vrp_pkg::ANGLE_W + 1;
  localparam int NW = XW + vrp_pkg::DIST_W;
  localparam int QB = vrp_pkg::QUOT_BITS;
  localparam int SW = QB + 2;

  logic signed [vrp_pkg::ANGLE_W-1:0] sin_angle, cos_angle;
  logic signed [CB-1:0]               cam_x, cam_y, cam_z;
  logic [vrp_pkg::DIST_W-1:0]         view_distance;
  logic [vrp_pkg::SCREEN_W-1:0]       screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_angle     <= '0;
      cos_angle     <= 16'sd16384;
      cam_x         <= '0;
      cam_y         <= '0;
      cam_z         <= CB'(65536);
      view_distance <= 12'd256;
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
    end else if (cfg_we) begin
      unique case (vrp_pkg::cfg_reg_t'(cfg_index))
        vrp_pkg::REG_SIN:    sin_angle     <= cfg_data[vrp_pkg::ANGLE_W-1:0];
        vrp_pkg::REG_COS:    cos_angle     <= cfg_data[vrp_pkg::ANGLE_W-1:0];
        vrp_pkg::REG_CAM_X:  cam_x         <= cfg_data;
        vrp_pkg::REG_CAM_Y:  cam_y         <= cfg_data;
        vrp_pkg::REG_CAM_Z:  cam_z         <= cfg_data;
        vrp_pkg::REG_DIST:   view_distance <= cfg_data[vrp_pkg::DIST_W-1:0];
        vrp_pkg::REG_WIDTH:  screen_width  <= cfg_data[vrp_pkg::SCREEN_W-1:0];
        vrp_pkg::REG_HEIGHT: screen_height <= cfg_data[vrp_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic                 rot_valid, rot_ready, rot_hidden;
  logic signed [XW-1:0] xr, yr, zr;

  vrp_rotate #(.CB(CB)) u_rotate (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .x          (s_axis_tdata[CB-1:0]),
    .y          (s_axis_tdata[2*CB-1:CB]),
    .z          (s_axis_tdata[3*CB-1:2*CB]),
    .hidden     (s_axis_tuser),
    .sin_angle  (sin_angle),
    .cos_angle  (cos_angle),
    .cam_x      (cam_x),
    .cam_y      (cam_y),
    .cam_z      (cam_z),
    .out_valid  (rot_valid),
    .out_ready  (rot_ready),
    .xr         (xr),
    .yr         (yr),
    .zr         (zr),
    .out_hidden (rot_hidden)
  );

  logic                scl_valid, scl_ready;
  logic [NW-1:0]       mag_x, mag_y;
  logic [XW-2:0]       den;
  vrp_pkg::vrp_flags_t scl_flags;

  vrp_scale #(.XW(XW), .FRAC_BITS(FRAC_BITS)) u_scale (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (rot_valid),
    .in_ready      (rot_ready),
    .xr            (xr),
    .yr            (yr),
    .zr            (zr),
    .hidden        (rot_hidden),
    .view_distance (view_distance),
    .out_valid     (scl_valid),
    .out_ready     (scl_ready),
    .mag_x         (mag_x),
    .mag_y         (mag_y),
    .den           (den),
    .flags         (scl_flags)
  );

  logic                div_valid, div_ready, ovf_x, ovf_y;
  logic [QB-1:0]       quot_x, quot_y;
  vrp_pkg::vrp_flags_t div_flags;

  vrp_div #(.NW(NW), .DW(XW - 1)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .num_x     (mag_x),
    .num_y     (mag_y),
    .den       (den),
    .in_flags  (scl_flags),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .quot_x    (quot_x),
    .quot_y    (quot_y),
    .ovf_x     (ovf_x),
    .ovf_y     (ovf_y),
    .out_flags (div_flags)
  );

  // screen mapping and 16-bit saturation
  logic [QB-1:0]        qmx, qmy;
  logic signed [SW-1:0] sqx, sqy, px, py;
  logic signed [vrp_pkg::OUT_W-1:0] sat_x, sat_y;

  always_comb begin
    qmx = ovf_x ? '1 : quot_x;
    qmy = ovf_y ? '1 : quot_y;
    sqx = div_flags.neg_x ? -signed'(SW'(qmx)) : signed'(SW'(qmx));
    sqy = div_flags.neg_y ? -signed'(SW'(qmy)) : signed'(SW'(qmy));
    px  = sqx + signed'(SW'(screen_width[vrp_pkg::SCREEN_W-1:1]));
    py  = signed'(SW'(screen_height[vrp_pkg::SCREEN_W-1:1])) - sqy;
    if (px > SW'(vrp_pkg::SAT_MAX)) begin
      sat_x = vrp_pkg::SAT_MAX;
    end else if (px < SW'(vrp_pkg::SAT_MIN)) begin
      sat_x = vrp_pkg::SAT_MIN;
    end else begin
      sat_x = px[vrp_pkg::OUT_W-1:0];
    end
    if (py > SW'(vrp_pkg::SAT_MAX)) begin
      sat_y = vrp_pkg::SAT_MAX;
    end else if (py < SW'(vrp_pkg::SAT_MIN)) begin
      sat_y = vrp_pkg::SAT_MIN;
    end else begin
      sat_y = py[vrp_pkg::OUT_W-1:0];
    end
  end

  assign div_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (div_ready) begin
      m_axis_tvalid <= div_valid;
    end
    if (div_ready) begin
      if (div_flags.vis) begin
        m_axis_tdata <= {sat_y, sat_x};
      end else begin
        m_axis_tdata <= {vrp_pkg::IGNORE_COORD, vrp_pkg::IGNORE_COORD};
      end
      m_axis_tuser <= div_flags.vis;
    end
  end

endmodule

// ===== hdl/vrp_checker.sv =====
module vrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a hidden or near vertex always shows the ignore marker in both coordinates
  a_ignore_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata == {vrp_pkg::IGNORE_COORD, vrp_pkg::IGNORE_COORD})
    else $error("invisible item without ignore marker");

  // empty output register means the whole pipeline can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled item changed");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
